/* hdl/anpt_pkg.sv */
// ----------------------------------------------------------------------------
// anpt_pkg
// Shared types and constants of the aging node presence table: event codes,
// register indexes, stream widths and the command and status groups between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package anpt_pkg;

    localparam int MAC_W    = 48;
    localparam int IP_W     = 32;
    localparam int LEVEL_W  = 8;
    localparam int TTL_W    = 8;
    localparam int DATA_W   = MAC_W + IP_W + LEVEL_W;
    localparam int EV_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [TTL_W-1:0] TTL_DEFAULT = 8'd130;

    localparam logic [CFG_IDX_W-1:0] CFG_TTL_RELOAD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IS_ROOT    = 1'd1;

    typedef enum logic [EV_W-1:0] {
        EV_JOINED    = 3'd0,
        EV_REFRESHED = 3'd1,
        EV_FULL      = 3'd2,
        EV_LEFT      = 3'd3,
        EV_TICK_DONE = 3'd4
    } t_event;

    // payload source of a result
    typedef enum logic [1:0] {
        SRC_SLOT = 2'd0,
        SRC_KEY  = 2'd1,
        SRC_ZERO = 2'd2
    } t_src;

    typedef struct packed {
        logic   load_key;
        logic   free_clr;
        logic   free_track;
        logic   rd_en;
        logic   clr_valid;
        logic   wr_ttl;
        logic   ttl_dec;
        logic   wr_join;
        logic   emit;
        logic   last;
        t_event ev;
        t_src   src;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic slot_valid;
        logic ttl_zero;
        logic mac_hit;
        logic free_fnd;
        logic is_root;
    } t_sts;

endpackage

/* hdl/anpt_dp.sv */
// ----------------------------------------------------------------------------
// anpt_dp
// Datapath: slot memories, valid bits, request key, free-slot tracker,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module anpt_dp #(
    parameter int TABLE_DEPTH = 16,
    parameter int IW          = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  anpt_pkg::t_cmd                   i_cmd,
    input  logic [IW-1:0]                    i_rd_addr,
    input  logic [IW-1:0]                    i_ev_addr,
    input  logic                             i_cfg_valid,
    input  logic [anpt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [anpt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [anpt_pkg::MAC_W-1:0]       i_key_mac,
    input  logic [anpt_pkg::IP_W-1:0]        i_key_ip,
    input  logic [anpt_pkg::LEVEL_W-1:0]     i_key_level,
    input  logic                             i_m_tready,
    output anpt_pkg::t_sts                   o_sts,
    output logic                             o_m_tvalid,
    output logic [anpt_pkg::DATA_W-1:0]      o_m_tdata,
    output logic [anpt_pkg::EV_W-1:0]        o_m_tuser,
    output logic                             o_m_tlast
);

    logic [anpt_pkg::MAC_W-1:0]   mem_mac   [TABLE_DEPTH];
    logic [anpt_pkg::IP_W-1:0]    mem_ip    [TABLE_DEPTH];
    logic [anpt_pkg::LEVEL_W-1:0] mem_level [TABLE_DEPTH];
    logic [anpt_pkg::TTL_W-1:0]   mem_ttl   [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0]       r_valid;
    logic [anpt_pkg::MAC_W-1:0]   r_q_mac;
    logic [anpt_pkg::IP_W-1:0]    r_q_ip;
    logic [anpt_pkg::LEVEL_W-1:0] r_q_level;
    logic [anpt_pkg::TTL_W-1:0]   r_q_ttl;

    logic [anpt_pkg::MAC_W-1:0]   r_key_mac;
    logic [anpt_pkg::IP_W-1:0]    r_key_ip;
    logic [anpt_pkg::LEVEL_W-1:0] r_key_level;

    logic                         r_free_fnd;
    logic [IW-1:0]                r_free_idx;

    logic [anpt_pkg::TTL_W-1:0]   r_ttl_reload;
    logic                         r_is_root;

    logic                         r_out_valid;
    logic [anpt_pkg::DATA_W-1:0]  r_out_data;
    anpt_pkg::t_event             r_out_ev;
    logic                         r_out_last;

    logic [IW-1:0]                w_wr_addr;
    logic [anpt_pkg::TTL_W-1:0]   w_ttl_data;
    logic [anpt_pkg::DATA_W-1:0]  w_emit_data;

    assign w_wr_addr  = i_cmd.wr_join ? r_free_idx : i_ev_addr;
    assign w_ttl_data = i_cmd.ttl_dec ? r_q_ttl - 8'd1 : r_ttl_reload;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_join) begin
            mem_mac[r_free_idx]   <= r_key_mac;
            mem_ip[r_free_idx]    <= r_key_ip;
            mem_level[r_free_idx] <= r_key_level;
        end
        if (i_cmd.rd_en) begin
            r_q_mac   <= mem_mac[i_rd_addr];
            r_q_ip    <= mem_ip[i_rd_addr];
            r_q_level <= mem_level[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_join || i_cmd.wr_ttl) begin
            mem_ttl[w_wr_addr] <= w_ttl_data;
        end
        if (i_cmd.rd_en) begin
            r_q_ttl <= mem_ttl[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_cmd.clr_valid) begin
                r_valid[i_ev_addr] <= 1'b0;
            end
            if (i_cmd.wr_join) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_key_mac   <= i_key_mac;
            r_key_ip    <= i_key_ip;
            r_key_level <= i_key_level;
        end
    end

    // lowest free slot seen during the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_fnd <= 1'b0;
        end else if (i_cmd.free_clr) begin
            r_free_fnd <= 1'b0;
        end else if (i_cmd.free_track && !r_valid[i_ev_addr] && !r_free_fnd) begin
            r_free_fnd <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.free_track && !r_valid[i_ev_addr] && !r_free_fnd) begin
            r_free_idx <= i_ev_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl_reload <= anpt_pkg::TTL_DEFAULT;
            r_is_root    <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                anpt_pkg::CFG_TTL_RELOAD: r_ttl_reload <= i_cfg_data;
                anpt_pkg::CFG_IS_ROOT:    r_is_root    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.src)
            anpt_pkg::SRC_SLOT: w_emit_data = {r_q_level, r_q_ip, r_q_mac};
            anpt_pkg::SRC_KEY:  w_emit_data = {r_key_level, r_key_ip, r_key_mac};
            default:            w_emit_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= w_emit_data;
            r_out_ev   <= i_cmd.ev;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_sts.out_free   = !r_out_valid || i_m_tready;
    assign o_sts.slot_valid = r_valid[i_ev_addr];
    assign o_sts.ttl_zero   = (r_q_ttl == '0);
    assign o_sts.mac_hit    = (r_q_mac == r_key_mac);
    assign o_sts.free_fnd   = r_free_fnd;
    assign o_sts.is_root    = r_is_root;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_ev;
    assign o_m_tlast  = r_out_last;

endmodule

/* hdl/anpt_ctrl.sv */
// ----------------------------------------------------------------------------
// anpt_ctrl
// Controller: accepts requests, walks the slots one per cycle unless stalled
// on a result, with the memory read running one slot ahead, and issues results.
// ----------------------------------------------------------------------------
module anpt_ctrl #(
    parameter int TABLE_DEPTH = 16,
    parameter int IW          = 4,
    parameter int CW          = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_opcode,
    output logic           o_s_tready,
    input  anpt_pkg::t_sts i_sts,
    output anpt_pkg::t_cmd o_cmd,
    output logic [IW-1:0]  o_rd_addr,
    output logic [IW-1:0]  o_ev_addr
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FINAL = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic          r_tick, n_tick;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [IW-1:0] r_ev_idx, n_ev_idx;
    logic          r_ev_vld, n_ev_vld;

    logic          w_need;
    logic          w_stall;

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_rd_addr  = r_rd_idx[IW-1:0];
    assign o_ev_addr  = r_ev_idx;

    assign w_need  = r_ev_vld && i_sts.slot_valid && (r_tick ? i_sts.ttl_zero : i_sts.mac_hit);
    assign w_stall = w_need && !i_sts.out_free;

    always_comb begin
        n_state  = r_state;
        n_tick   = r_tick;
        n_rd_idx = r_rd_idx;
        n_ev_idx = r_ev_idx;
        n_ev_vld = r_ev_vld;
        o_cmd    = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_key = 1'b1;
                    o_cmd.free_clr = 1'b1;
                    n_tick   = i_opcode;
                    n_rd_idx = '0;
                    n_ev_vld = 1'b0;
                    n_state  = (i_opcode && !i_sts.is_root) ? ST_FINAL : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!r_ev_vld && r_rd_idx == CW'(TABLE_DEPTH)) begin
                    n_state = ST_FINAL;
                end else if (!w_stall) begin
                    if (r_ev_vld) begin
                        if (r_tick) begin
                            if (i_sts.slot_valid && i_sts.ttl_zero) begin
                                o_cmd.clr_valid = 1'b1;
                                o_cmd.emit      = 1'b1;
                                o_cmd.ev        = anpt_pkg::EV_LEFT;
                                o_cmd.src       = anpt_pkg::SRC_SLOT;
                            end else if (i_sts.slot_valid) begin
                                o_cmd.wr_ttl  = 1'b1;
                                o_cmd.ttl_dec = 1'b1;
                            end
                        end else begin
                            o_cmd.free_track = 1'b1;
                            if (w_need) begin
                                o_cmd.wr_ttl = 1'b1;
                                o_cmd.emit   = 1'b1;
                                o_cmd.last   = 1'b1;
                                o_cmd.ev     = anpt_pkg::EV_REFRESHED;
                                o_cmd.src    = anpt_pkg::SRC_SLOT;
                                n_state      = ST_IDLE;
                            end
                        end
                    end
                    if (r_rd_idx != CW'(TABLE_DEPTH)) begin
                        o_cmd.rd_en = 1'b1;
                        n_ev_idx = r_rd_idx[IW-1:0];
                        n_ev_vld = 1'b1;
                        n_rd_idx = r_rd_idx + 1'b1;
                    end else begin
                        n_ev_vld = 1'b0;
                    end
                end
            end
            ST_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    if (r_tick) begin
                        o_cmd.ev  = anpt_pkg::EV_TICK_DONE;
                        o_cmd.src = anpt_pkg::SRC_ZERO;
                    end else if (i_sts.free_fnd) begin
                        o_cmd.wr_join = 1'b1;
                        o_cmd.ev      = anpt_pkg::EV_JOINED;
                        o_cmd.src     = anpt_pkg::SRC_KEY;
                    end else begin
                        o_cmd.ev  = anpt_pkg::EV_FULL;
                        o_cmd.src = anpt_pkg::SRC_KEY;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ev_vld <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            r_state  <= n_state;
            r_ev_vld <= n_ev_vld;
            r_rd_idx <= n_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tick   <= n_tick;
        r_ev_idx <= n_ev_idx;
    end

endmodule

/* hdl/aging_node_presence_table_top.sv */
// ----------------------------------------------------------------------------
// aging_node_presence_table_top
// Table of child nodes with TTL aging: reports join or refresh an entry,
// ticks age the table and give leave events in slot order.
// ----------------------------------------------------------------------------
// Answers: a report hit at slot k answers when the scan reaches slot k; a join
//   or full answer, and a tick, follow the full scan; a tick when not root skips it.
// Requests: one request at a time, paced by the slot scan over the single memory
//   read port; result stalls hold the scan.
// Reset: synchronous, active low; clears all valid bits at once and loads
//   ttl_reload 130 and is_root 1. No clearing pass.
module aging_node_presence_table_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // mac_address[47:0], ip_address[79:48], node_level[87:80]
    input  logic [anpt_pkg::DATA_W-1:0]         s_axis_tdata,
    // opcode[0]
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_mac[47:0], out_ip[79:48], out_level[87:80]
    output logic [anpt_pkg::DATA_W-1:0]         m_axis_tdata,
    // event_res[2:0]
    output logic [anpt_pkg::EV_W-1:0]           m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [anpt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [anpt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    anpt_pkg::t_cmd w_cmd;
    anpt_pkg::t_sts w_sts;
    logic [IW-1:0]  w_rd_addr;
    logic [IW-1:0]  w_ev_addr;

    assign o_cfg_ready = 1'b1;

    anpt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IW          (IW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser[0]),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_rd_addr  (w_rd_addr),
        .o_ev_addr  (w_ev_addr)
    );

    anpt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IW          (IW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_rd_addr   (w_rd_addr),
        .i_ev_addr   (w_ev_addr),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_key_mac   (s_axis_tdata[47:0]),
        .i_key_ip    (s_axis_tdata[79:48]),
        .i_key_level (s_axis_tdata[87:80]),
        .i_m_tready  (m_axis_tready),
        .o_sts       (w_sts),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tlast   (m_axis_tlast)
    );

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_sts.out_free)
        else $error("result issued while result register occupied");

    a_join_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_join |-> (w_sts.free_fnd && w_cmd.ev == anpt_pkg::EV_JOINED))
        else $error("join written without a free slot");

    a_left_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == anpt_pkg::EV_LEFT) |-> !m_axis_tlast)
        else $error("leave event marked last");

    a_tick_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == anpt_pkg::EV_TICK_DONE)
            |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("tick done with payload or without last");

endmodule
